[rtl/tsor_pkg.sv]
// ----------------------------------------------------------------------------
// Timestamp offset or rescale: shared definitions
// Register indexes, mode and role codes, the word carried down the pipeline,
// the divider step and the 32-bit clamp.
// ----------------------------------------------------------------------------
package tsor_pkg;

   // Configuration register indexes.
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 33;
   localparam logic [CSR_IDX_W-1:0] CSR_MODE      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OLD_FIRST = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_OLD_LAST  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_NEW_FIRST = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_NEW_LAST  = 3'd5;

   // Mode and role codes.
   localparam logic [1:0] MODE_OFFSET    = 2'd1;
   localparam logic [1:0] MODE_RESCALE   = 2'd2;
   localparam logic [1:0] ROLE_END       = 2'd1;
   localparam logic [1:0] ROLE_END_START = 2'd2;

   localparam int unsigned MS_W      = 26;
   localparam int unsigned TICKS_PER_MS = 90;
   // Divider: 27-bit divisor, 34 quotient bits, two bits per stage.
   localparam int unsigned DVS_W     = MS_W + 1;
   localparam int unsigned QUO_W     = 34;
   localparam int unsigned DIV_STAGES = QUO_W / 2;

   // Per-word fields that travel alongside the arithmetic.
   typedef struct packed {
      logic [31:0]        pts;
      logic signed [32:0] lead;      // dts - pts
      logic signed [32:0] adj;       // pts - span start
      logic [31:0]        pts_pos;
      logic [31:0]        dts_pos;
      logic               ending;
      logic               offs;      // offset mode
      logic               err;
   } item_type;

   // Partial remainder and the dividend/quotient shift register.
   typedef struct packed {
      logic [DVS_W-1:0] rem;
      logic [QUO_W-1:0] qd;
   } div_type;

   // Two restoring division steps. The remainder stays below the divisor when it starts below it.
   function automatic div_type div_step(div_type x, logic [DVS_W-1:0] dvs);
      logic [DVS_W:0]   r;
      logic [DVS_W-1:0] rm;
      logic [QUO_W-1:0] qd;
      div_type          y;
      rm = x.rem;
      qd = x.qd;
      for (int i = 0; i < 2; i++) begin
         r  = {rm, qd[QUO_W-1]};
         qd = {qd[QUO_W-2:0], 1'b0};
         if (r >= {1'b0, dvs}) begin
            r     = r - {1'b0, dvs};
            qd[0] = 1'b1;
         end
         rm = r[DVS_W-1:0];
      end
      y.rem = rm;
      y.qd  = qd;
      return y;
   endfunction

   // Saturate a 35-bit signed value to 0..2^32-1.
   function automatic logic [31:0] clamp_u32(logic signed [34:0] v);
      logic [31:0] c;
      if (v[34]) begin
         c = 32'd0;
      end else if (|v[33:32]) begin
         c = 32'hFFFF_FFFF;
      end else begin
         c = v[31:0];
      end
      return c;
   endfunction

endpackage

[rtl/timestamp_offset_or_rescale.sv]
// ----------------------------------------------------------------------------
// Timestamp offset or rescale: each kept word goes through 4 front stages, 17 two-bit
// divider stages for the rescale quotient, and 2 stages of add and clamp before the output.
// It accepts one word per cycle while rsp_stall does not hold the pipeline.
// Synchronous reset empties the pipeline and loads the register reset values.
// ----------------------------------------------------------------------------
module timestamp_offset_or_rescale (
   input  logic                               clock,
   input  logic                               reset,
   // Configuration port
   input  logic                               csr_write_en,
   input  logic [tsor_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [tsor_pkg::CSR_DATA_W-1:0]    csr_wdata,
   // Request channel
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [31:0]                        req_pts_in,
   input  logic [31:0]                        req_dts_in,
   input  logic [31:0]                        req_pts_position,
   input  logic [31:0]                        req_dts_position,
   input  logic [1:0]                         req_role,
   input  logic [31:0]                        req_span_start,
   input  logic [31:0]                        req_span_end,
   input  logic                               req_span_present,
   input  logic                               req_prescan,
   // Response channel
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [31:0]                        rsp_pts_out,
   output logic [31:0]                        rsp_dts_out,
   output logic [31:0]                        rsp_pts_where,
   output logic [31:0]                        rsp_dts_where,
   output logic                               rsp_error
);
   import tsor_pkg::*;

   // Configuration registers.
   logic [1:0]         mode_ff;
   logic signed [32:0] offset_ff;
   logic [MS_W-1:0]    old_first_ff;
   logic [MS_W-1:0]    old_last_ff;
   logic [MS_W-1:0]    new_first_ff;
   logic [MS_W-1:0]    new_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= '0;
         offset_ff    <= '0;
         old_first_ff <= '0;
         old_last_ff  <= MS_W'(1);
         new_first_ff <= '0;
         new_last_ff  <= MS_W'(1);
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_MODE:      mode_ff      <= csr_wdata[1:0];
            CSR_OFFSET:    offset_ff    <= $signed(csr_wdata);
            CSR_OLD_FIRST: old_first_ff <= csr_wdata[MS_W-1:0];
            CSR_OLD_LAST:  old_last_ff  <= csr_wdata[MS_W-1:0];
            CSR_NEW_FIRST: new_first_ff <= csr_wdata[MS_W-1:0];
            CSR_NEW_LAST:  new_last_ff  <= csr_wdata[MS_W-1:0];
            default: ;
         endcase
      end
   end

   // Constants derived from the interval registers. The divisor is kept
   // positive; the sign of the old span is folded into the new span instead.
   logic signed [MS_W:0] den_in, nsp_in;
   logic [32:0]          of90_ff, nf90_ff;
   logic [MS_W-1:0]      abs_den_ff;
   logic signed [MS_W:0] nspe_ff;
   logic                 den_zero_ff;
   logic [DVS_W-1:0]     dvs;

   assign den_in = $signed({1'b0, old_last_ff}) - $signed({1'b0, old_first_ff});
   assign nsp_in = $signed({1'b0, new_last_ff}) - $signed({1'b0, new_first_ff});
   assign dvs    = {abs_den_ff, 1'b0};

   always_ff @(posedge clock) begin
      of90_ff     <= 33'(old_first_ff) * 33'(TICKS_PER_MS);
      nf90_ff     <= 33'(new_first_ff) * 33'(TICKS_PER_MS);
      abs_den_ff  <= den_in[MS_W] ? MS_W'(-den_in) : den_in[MS_W-1:0];
      nspe_ff     <= den_in[MS_W] ? -nsp_in : nsp_in;
      den_zero_ff <= (den_in == '0);
   end

   // Ready chain: a stage loads when it is empty or the next stage loads.
   logic s1_v_ff, s2_v_ff, s3_v_ff, s4_v_ff, f1_v_ff, f2_v_ff, out_v_ff;
   logic s1_rdy, s2_rdy, s3_rdy, s4_rdy, f1_rdy, f2_rdy, out_rdy;
   logic [DIV_STAGES-1:0] dv_v_ff;
   logic [DIV_STAGES-1:0] dv_rdy;

   assign out_rdy = !out_v_ff || !rsp_stall;
   assign f2_rdy  = !f2_v_ff || out_rdy;
   assign f1_rdy  = !f1_v_ff || f2_rdy;
   assign s4_rdy  = !s4_v_ff || dv_rdy[0];
   assign s3_rdy  = !s3_v_ff || s4_rdy;
   assign s2_rdy  = !s2_v_ff || s3_rdy;
   assign s1_rdy  = !s1_v_ff || s2_rdy;
   assign req_stall = !s1_rdy;

   // Stage 1: capture the word. Prescan words and words with no valid mode set are
   // accepted and dropped here.
   item_type    s1_item_ff, s1_item_in;
   logic [31:0] s1_t_ff;
   logic        req_keep;
   logic        req_ending;

   assign req_ending = (req_role == ROLE_END) || (req_role == ROLE_END_START);
   assign req_keep   = !req_prescan && ((mode_ff == MODE_OFFSET) || (mode_ff == MODE_RESCALE));

   always_comb begin
      s1_item_in.pts     = req_pts_in;
      s1_item_in.lead    = $signed({1'b0, req_dts_in}) - $signed({1'b0, req_pts_in});
      s1_item_in.adj     = $signed({1'b0, req_pts_in}) - $signed({1'b0, req_span_start});
      s1_item_in.pts_pos = req_pts_position;
      s1_item_in.dts_pos = req_dts_position;
      s1_item_in.ending  = req_ending;
      s1_item_in.offs    = (mode_ff == MODE_OFFSET);
      s1_item_in.err     = (mode_ff != MODE_OFFSET) && req_ending &&
                           (!req_span_present || (req_span_end < req_span_start));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (s1_rdy) begin
         s1_v_ff <= req_valid && req_keep;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_rdy) begin
         s1_item_ff <= s1_item_in;
         s1_t_ff    <= req_ending ? req_span_start : req_pts_in;
      end
   end

   // Stage 2: distance of the time from the old interval start, in ticks.
   item_type           s2_item_ff, s2_item_in;
   logic signed [33:0] s2_diff_ff;

   always_comb begin
      s2_item_in     = s1_item_ff;
      s2_item_in.err = !s1_item_ff.offs && (s1_item_ff.err || den_zero_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else if (s2_rdy) begin
         s2_v_ff <= s1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_rdy) begin
         s2_item_ff <= s2_item_in;
         s2_diff_ff <= $signed({2'b00, s1_t_ff}) - $signed({1'b0, of90_ff});
      end
   end

   // Stage 3: numerator, distance times the signed new span.
   item_type           s3_item_ff;
   logic signed [60:0] s3_num_ff, s3_num_in;

   assign s3_num_in = s2_diff_ff * nspe_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_v_ff <= 1'b0;
      end else if (s3_rdy) begin
         s3_v_ff <= s2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_rdy) begin
         s3_item_ff <= s2_item_ff;
         s3_num_ff  <= s3_num_in;
      end
   end

   // Stage 4: rounding dividend 2*num + den. A negative dividend a is divided
   // as ~a (that is -a-1), and the floor quotient is then ~quotient.
   item_type           s4_item_ff;
   logic [60:0]        s4_a_ff;
   logic               s4_neg_ff;
   logic signed [61:0] s4_a_in;

   assign s4_a_in = $signed({s3_num_ff, 1'b0}) + $signed({36'd0, abs_den_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_v_ff <= 1'b0;
      end else if (s4_rdy) begin
         s4_v_ff <= s3_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s4_rdy) begin
         s4_item_ff <= s3_item_ff;
         s4_neg_ff  <= s4_a_in[61];
         s4_a_ff    <= s4_a_in[61] ? ~s4_a_in[60:0] : s4_a_in[60:0];
      end
   end

   // Divider pipeline, two quotient bits per stage. A quotient of 2^34 or
   // more is flagged as saturated in the first stage.
   div_type  dv_ff     [DIV_STAGES];
   div_type  dv_src    [DIV_STAGES];
   logic     dv_sat_ff [DIV_STAGES];
   logic     dv_sat_src[DIV_STAGES];
   logic     dv_neg_ff [DIV_STAGES];
   logic     dv_neg_src[DIV_STAGES];
   item_type dv_item_ff [DIV_STAGES];
   item_type dv_item_src[DIV_STAGES];
   logic [DIV_STAGES-1:0] dv_v_src;

   always_comb begin
      dv_src[0].rem  = s4_a_ff[60:QUO_W];
      dv_src[0].qd   = s4_a_ff[QUO_W-1:0];
      dv_sat_src[0]  = (s4_a_ff[60:QUO_W] >= dvs);
      dv_neg_src[0]  = s4_neg_ff;
      dv_item_src[0] = s4_item_ff;
      dv_v_src[0]    = s4_v_ff;
      for (int k = 1; k < DIV_STAGES; k++) begin
         dv_src[k]      = dv_ff[k-1];
         dv_sat_src[k]  = dv_sat_ff[k-1];
         dv_neg_src[k]  = dv_neg_ff[k-1];
         dv_item_src[k] = dv_item_ff[k-1];
         dv_v_src[k]    = dv_v_ff[k-1];
      end
   end

   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
      if (k == DIV_STAGES - 1) begin : g_last
         assign dv_rdy[k] = !dv_v_ff[k] || f1_rdy;
      end else begin : g_mid
         assign dv_rdy[k] = !dv_v_ff[k] || dv_rdy[k+1];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_v_ff[k] <= 1'b0;
         end else if (dv_rdy[k]) begin
            dv_v_ff[k] <= dv_v_src[k];
         end
      end

      always_ff @(posedge clock) begin
         if (dv_rdy[k]) begin
            dv_ff[k]      <= div_step(dv_src[k], dvs);
            dv_sat_ff[k]  <= dv_sat_src[k];
            dv_neg_ff[k]  <= dv_neg_src[k];
            dv_item_ff[k] <= dv_item_src[k];
         end
      end
   end

   // Final 1: signed quotient plus the new interval start, clamped.
   item_type           f1_item_ff;
   logic [31:0]        f1_r_ff, f1_r_in;
   logic signed [34:0] q_in;
   logic signed [35:0] r_sum_in;
   logic               last_sat, last_neg;

   assign last_sat = dv_sat_ff[DIV_STAGES-1];
   assign last_neg = dv_neg_ff[DIV_STAGES-1];
   assign q_in     = last_neg ? ~{1'b0, dv_ff[DIV_STAGES-1].qd}
                              :  {1'b0, dv_ff[DIV_STAGES-1].qd};
   assign r_sum_in = $signed({3'b000, nf90_ff}) + $signed({q_in[34], q_in});

   always_comb begin
      if (last_sat) begin
         f1_r_in = last_neg ? 32'd0 : 32'hFFFF_FFFF;
      end else if (r_sum_in[35]) begin
         f1_r_in = 32'd0;
      end else if (|r_sum_in[34:32]) begin
         f1_r_in = 32'hFFFF_FFFF;
      end else begin
         f1_r_in = r_sum_in[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_v_ff <= 1'b0;
      end else if (f1_rdy) begin
         f1_v_ff <= dv_v_ff[DIV_STAGES-1];
      end
   end

   always_ff @(posedge clock) begin
      if (f1_rdy) begin
         f1_item_ff <= dv_item_ff[DIV_STAGES-1];
         f1_r_ff    <= f1_r_in;
      end
   end

   // Final 2: unclamped new presentation time. An ending segment keeps its
   // distance from the span start; offset mode adds the offset instead.
   item_type           f2_item_ff;
   logic signed [34:0] f2_p_ff, f2_p_in;

   always_comb begin
      if (f1_item_ff.offs) begin
         f2_p_in = $signed({3'b000, f1_item_ff.pts}) +
                   $signed({{2{offset_ff[32]}}, offset_ff});
      end else if (f1_item_ff.ending) begin
         f2_p_in = $signed({3'b000, f1_r_ff}) +
                   $signed({{2{f1_item_ff.adj[32]}}, f1_item_ff.adj});
      end else begin
         f2_p_in = $signed({3'b000, f1_r_ff});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f2_v_ff <= 1'b0;
      end else if (f2_rdy) begin
         f2_v_ff <= f1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (f2_rdy) begin
         f2_item_ff <= f1_item_ff;
         f2_p_ff    <= f2_p_in;
      end
   end

   // Output register: decode time keeps its lead over the presentation time.
   logic signed [34:0] dts_sum_in;
   logic [31:0]        rsp_pts_ff, rsp_dts_ff, rsp_pts_where_ff, rsp_dts_where_ff;
   logic               rsp_error_ff;

   assign dts_sum_in = f2_p_ff + $signed({{2{f2_item_ff.lead[32]}}, f2_item_ff.lead});

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (out_rdy) begin
         out_v_ff <= f2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_rdy) begin
         rsp_pts_ff       <= f2_item_ff.err ? 32'd0 : clamp_u32(f2_p_ff);
         rsp_dts_ff       <= f2_item_ff.err ? 32'd0 : clamp_u32(dts_sum_in);
         rsp_pts_where_ff <= f2_item_ff.pts_pos;
         rsp_dts_where_ff <= f2_item_ff.dts_pos;
         rsp_error_ff     <= f2_item_ff.err;
      end
   end

   assign rsp_valid     = out_v_ff;
   assign rsp_pts_out   = rsp_pts_ff;
   assign rsp_dts_out   = rsp_dts_ff;
   assign rsp_pts_where = rsp_pts_where_ff;
   assign rsp_dts_where = rsp_dts_where_ff;
   assign rsp_error     = rsp_error_ff;

endmodule
